FILE: hdl/bigram_topk_follower_table_top_assert.svh
// Assertion macros for the bigram follower table.
`ifndef BIGRAM_TOPK_FOLLOWER_TABLE_TOP_ASSERT_SVH
`define BIGRAM_TOPK_FOLLOWER_TABLE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BTF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bigram follower table: check failed");
// Implication checked in the cycle after the antecedent.
`define BTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bigram follower table: check failed");
`endif

FILE: hdl/btf_pkg.sv
// ----------------------------------------------------------------------------
// btf_pkg
// Shared types and constants of the bigram follower table.
// ----------------------------------------------------------------------------
package btf_pkg;
  localparam int unsigned ROW_BITS = 28;
  localparam int unsigned OUT_CNT_BITS = 20;
  localparam int unsigned CFG_BITS = 20;
  localparam int unsigned CFG_RESET = 10;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;
endpackage

FILE: hdl/bigram_topk_follower_table_top.sv
// ----------------------------------------------------------------------------
// bigram_topk_follower_table_top
// Counts byte pairs and reports the top followers of a leading byte.
// ----------------------------------------------------------------------------
// After reset the block sweeps both count memories before the first request
// is taken; a clear request does the same sweep. An add request reads both
// memories, then writes the incremented counts back through the shared pair
// and row memories. A query reads the row total, then reads the row's pair
// counts one follower per cycle, inserting each into a TOP_K slot register
// list, then reads each slot's count back. A row total below the configured
// minimum, or a leading byte out of range, gives a single rare response.
// Pair counters are COUNT_BITS wide.
module bigram_topk_follower_table_top #(
  parameter int unsigned TOP_K      = 10,
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned SYMBOLS    = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  query_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  leading_o,
  output logic [7:0]  follower_o,
  output logic [19:0] pair_count_o,
  output logic [27:0] row_sum_o,
  output logic [3:0]  rank_o,
  output logic        rare_o,
  output logic        last_o
);
  localparam int unsigned SB = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned AB = 2 * SB;
  localparam int unsigned KB = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int unsigned RB = btf_pkg::ROW_BITS;
  localparam int unsigned CFG_W = btf_pkg::CFG_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [RB-1:0] ROW_MAX = '1;
  localparam logic [SB:0] SYM_END = (SB+1)'(SYMBOLS);
  localparam logic [AB:0] CLR_END = (AB+1)'(SYMBOLS * SYMBOLS);
  localparam logic [KB:0] K_END = (KB+1)'(TOP_K);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_Q_RD, S_Q_CHK,
    S_SCAN, S_SCAN_LAST, S_RD_SLOT, S_OUT_WAIT, S_OUT
  } state_e;

  logic [COUNT_BITS-1:0] pair_mem [SYMBOLS*SYMBOLS];
  logic [RB-1:0]         row_mem  [SYMBOLS];

  state_e              state_q;
  logic [AB:0]         clr_q;
  logic [7:0]          prev_q;
  logic                have_prev_q;
  logic [7:0]          db_q;
  logic [7:0]          lead_q;
  logic [SB:0]         scan_q;
  logic [SB-1:0]       fol_rd_q;
  logic [KB:0]         k_q;
  logic [RB-1:0]       sum_q;
  logic [CFG_W-1:0]    min_q;
  logic [SB-1:0]         slot_f_q [TOP_K];
  logic [COUNT_BITS-1:0] slot_c_q [TOP_K];

  logic                  p_we, r_we;
  logic [AB-1:0]         p_waddr, p_raddr;
  logic [COUNT_BITS-1:0] p_wdata, p_rdata_q;
  logic [SB-1:0]         r_waddr, r_raddr;
  logic [RB-1:0]         r_wdata, r_rdata_q;

  logic [TOP_K-1:0] gt;
  logic [TOP_K-1:0] first;

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pair_mem[p_waddr] <= p_wdata;
    end
    p_rdata_q <= pair_mem[p_raddr];
    if (r_we) begin
      row_mem[r_waddr] <= r_wdata;
    end
    r_rdata_q <= row_mem[r_raddr];
  end

  always_comb begin
    for (int t = 0; t < TOP_K; t++) begin
      gt[t] = p_rdata_q > slot_c_q[t];
    end
    first[0] = gt[0];
    for (int t = 1; t < TOP_K; t++) begin
      first[t] = gt[t] && !gt[t-1];
    end
  end

  always_comb begin
    p_we    = 1'b0;
    r_we    = 1'b0;
    p_waddr = {prev_q[SB-1:0], db_q[SB-1:0]};
    r_waddr = prev_q[SB-1:0];
    p_wdata = (p_rdata_q < CNT_MAX) ? p_rdata_q + 1'b1 : p_rdata_q;
    r_wdata = (r_rdata_q < ROW_MAX) ? r_rdata_q + 1'b1 : r_rdata_q;
    p_raddr = {prev_q[SB-1:0], db_q[SB-1:0]};
    r_raddr = prev_q[SB-1:0];
    unique case (state_q)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_q[AB-1:0];
        p_wdata = '0;
        r_we    = 1'b1;
        r_waddr = clr_q[SB-1:0];
        r_wdata = '0;
      end
      S_ADD_WR: begin
        p_we = 1'b1;
        r_we = 1'b1;
      end
      S_Q_RD: r_raddr = lead_q[SB-1:0];
      S_Q_CHK, S_SCAN, S_SCAN_LAST:
        p_raddr = {lead_q[SB-1:0], scan_q[SB-1:0]};
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      min_q       <= CFG_W'(btf_pkg::CFG_RESET);
      out_valid_o <= 1'b0;
      scan_q      <= '0;
      k_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        min_q <= cfg_data_i;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CLR_END - 1'b1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            priority case (btf_pkg::mode_e'(mode_i))
              btf_pkg::MODE_ADD: begin
                if ({1'b0, data_byte_i} < 9'(SYMBOLS)) begin
                  db_q <= data_byte_i;
                  have_prev_q <= 1'b1;
                  if (have_prev_q) begin
                    state_q <= S_ADD_RD;
                  end else begin
                    prev_q <= data_byte_i;
                  end
                end
              end
              btf_pkg::MODE_QUERY: begin
                lead_q <= query_byte_i;
                state_q <= S_Q_RD;
              end
              btf_pkg::MODE_CLEAR: begin
                clr_q   <= '0;
                state_q <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_ADD_RD: state_q <= S_ADD_WR;
        S_ADD_WR: begin
          prev_q  <= db_q;
          state_q <= S_IDLE;
        end
        S_Q_RD: state_q <= S_Q_CHK;
        S_Q_CHK: begin
          leading_o  <= lead_q;
          follower_o <= '0;
          pair_count_o <= '0;
          rank_o     <= '0;
          rare_o     <= 1'b1;
          last_o     <= 1'b1;
          if ({1'b0, lead_q} >= 9'(SYMBOLS)) begin
            row_sum_o   <= '0;
            out_valid_o <= 1'b1;
            state_q     <= S_OUT_WAIT;
          end else if (r_rdata_q < RB'(min_q)) begin
            row_sum_o   <= r_rdata_q;
            out_valid_o <= 1'b1;
            state_q     <= S_OUT_WAIT;
          end else begin
            sum_q <= r_rdata_q;
            for (int t = 0; t < TOP_K; t++) begin
              slot_f_q[t] <= '0;
              slot_c_q[t] <= '0;
            end
            scan_q  <= (SB+1)'(1);
            state_q <= S_SCAN;
          end
        end
        S_SCAN, S_SCAN_LAST: begin
          // p_rdata_q holds the count of follower fol_rd_q (on the first step, of the follower left in
          // scan_q by the last query); the first step seeds every slot with that count
          if (fol_rd_q == '0) begin
            for (int t = 0; t < TOP_K; t++) begin
              slot_f_q[t] <= '0;
              slot_c_q[t] <= p_rdata_q;
            end
          end else begin
            for (int t = 0; t < TOP_K; t++) begin
              if (gt[t]) begin
                if (first[t]) begin
                  slot_f_q[t] <= fol_rd_q;
                  slot_c_q[t] <= p_rdata_q;
                end else begin
                  slot_f_q[t] <= slot_f_q[t-1 < 0 ? 0 : t-1];
                  slot_c_q[t] <= slot_c_q[t-1 < 0 ? 0 : t-1];
                end
              end
            end
          end
          if (state_q == S_SCAN_LAST) begin
            k_q     <= '0;
            state_q <= S_RD_SLOT;
          end else begin
            scan_q <= scan_q + 1'b1;
            if (scan_q == SYM_END - 1'b1) begin
              state_q <= S_SCAN_LAST;
            end
          end
        end
        S_RD_SLOT: begin
          leading_o    <= lead_q;
          follower_o   <= 8'(slot_f_q[k_q[KB-1:0]]);
          pair_count_o <= btf_pkg::OUT_CNT_BITS'(
            (slot_c_q[k_q[KB-1:0]] > COUNT_BITS'(20'hFFFFF)) ?
              COUNT_BITS'(20'hFFFFF) : slot_c_q[k_q[KB-1:0]]);
          row_sum_o    <= sum_q;
          rank_o       <= 4'(k_q);
          rare_o       <= 1'b0;
          last_o       <= (k_q == K_END - 1'b1);
          out_valid_o  <= 1'b1;
          state_q      <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            if (last_o) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_RD_SLOT;
            end
          end
        end
        S_OUT_WAIT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // follower index of the count now in p_rdata_q, except for the first scan step, where it is forced to 0
  always_ff @(posedge clk_i) begin
    if (state_q == S_Q_CHK) begin
      fol_rd_q <= '0;
    end else begin
      fol_rd_q <= scan_q[SB-1:0];
    end
  end

  `include "bigram_topk_follower_table_top_assert.svh"

  `BTF_ASSERT_IMP(a_busy_no_ready, state_q != S_IDLE, !in_ready_o)
  `BTF_ASSERT_IMP(a_out_only_when_reporting,
    out_valid_o, state_q == S_OUT || state_q == S_OUT_WAIT)
  `BTF_ASSERT_IMP(a_rare_is_last, out_valid_o && rare_o, last_o)
  `BTF_ASSERT_NEXT(a_add_writes_back, state_q == S_ADD_RD, state_q == S_ADD_WR)
endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Bigram follower table testbench
// Feeds byte streams, queries and clears through the request port. It keeps
// its own pair and row tables and reruns the top-K insertion ranking for
// every non-rare query. Each response is checked field by field, in order,
// against the expected response queue. Both sides idle at random. One long
// receiver hold-off stalls the input.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [7:0]  leading;
    logic [7:0]  follower;
    logic [19:0] pair_count;
    logic [27:0] row_sum;
    logic [3:0]  rank;
    logic        rare;
    logic        last;
  } resp_t;

  class follower_scoreboard;
    int unsigned pair_tbl [0:65535];
    int unsigned row_tbl [0:255];
    logic [7:0]  prev_byte;
    bit          have_prev;
    int unsigned min_total;
    resp_t       pending [$];
    int          mismatches;

    function void reset_state();
      foreach (pair_tbl[i]) pair_tbl[i] = 0;
      foreach (row_tbl[i]) row_tbl[i] = 0;
      prev_byte = 0;
      have_prev = 0;
      min_total = btf_pkg::CFG_RESET;
      mismatches = 0;
    endfunction

    function void note_request(btf_pkg::mode_e mode, logic [7:0] db, logic [7:0] qb);
      int unsigned idx;
      int unsigned total;
      logic [7:0]  slots [0:9];
      resp_t       r;
      case (mode)
        btf_pkg::MODE_ADD: begin
          if (have_prev) begin
            idx = {prev_byte, db};
            if (pair_tbl[idx] < 20'hFFFFF) pair_tbl[idx]++;
            if (row_tbl[prev_byte] < 28'hFFFFFFF) row_tbl[prev_byte]++;
          end
          prev_byte = db;
          have_prev = 1;
        end
        btf_pkg::MODE_CLEAR: begin
          foreach (pair_tbl[i]) pair_tbl[i] = 0;
          foreach (row_tbl[i]) row_tbl[i] = 0;
        end
        btf_pkg::MODE_QUERY: begin
          total = row_tbl[qb];
          if (total < min_total) begin
            r = '{qb, 8'd0, 20'd0, total[27:0], 4'd0, 1'b1, 1'b1};
            pending.push_back(r);
          end else begin
            foreach (slots[t]) slots[t] = 0;
            for (int b = 0; b < 256; b++) begin
              for (int t = 0; t < 10; t++) begin
                if (pair_tbl[{qb, b[7:0]}] > pair_tbl[{qb, slots[t]}]) begin
                  for (int s = 9; s > t; s--) slots[s] = slots[s-1];
                  slots[t] = b[7:0];
                  break;
                end
              end
            end
            for (int t = 0; t < 10; t++) begin
              idx = {qb, slots[t]};
              r = '{qb, slots[t], pair_tbl[idx][19:0], total[27:0], t[3:0], 1'b0,
                    (t == 9)};
              pending.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_response(resp_t got);
      resp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [19:0] cfg_data_i = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [1:0]  mode_i = btf_pkg::MODE_ADD;
  logic [7:0]  data_byte_i = 0;
  logic [7:0]  query_byte_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [7:0]  leading_o;
  logic [7:0]  follower_o;
  logic [19:0] pair_count_o;
  logic [27:0] row_sum_o;
  logic [3:0]  rank_o;
  logic        rare_o;
  logic        last_o;

  follower_scoreboard sb = new();
  bit          calm = 0;
  int          hold_off = 0;
  longint      cycles = 0;

  bigram_topk_follower_table_top u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd8_000_000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver side
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_response('{leading_o, follower_o, pair_count_o, row_sum_o, rank_o,
                          rare_o, last_o});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold_off <= $urandom_range(0, 2);
      out_ready_i <= 0;
    end else begin
      out_ready_i <= 1;
    end
  end

  // valid stays high from one request to the next unless an idle burst or
  // a config write comes in between
  task automatic send_request(btf_pkg::mode_e mode, logic [7:0] db, logic [7:0] qb);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    mode_i <= mode;
    data_byte_i <= db;
    query_byte_i <= qb;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(mode, db, qb);
  endtask

  task automatic write_min_total(logic [19:0] value);
    in_valid_i <= 0;
    wait (sb.pending.size() == 0);
    repeat (400) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    sb.min_total = value;
  endtask

  task automatic send_words(int n, int span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7)
        send_request(btf_pkg::MODE_ADD, 8'($urandom_range(0, span)), 8'($urandom));
      else if ($urandom_range(0, 12) == 0)
        send_request(btf_pkg::mode_e'(btf_pkg::MODE_NONE), 8'($urandom), 8'($urandom));
      else
        send_request(btf_pkg::MODE_QUERY, 8'($urandom), 8'($urandom_range(0, span)));
    end
  endtask

  initial begin
    sb.reset_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;

    // directed: first byte, extremes, rare, unused mode, clear
    send_request(btf_pkg::MODE_QUERY, 8'h00, 8'hFF);
    send_request(btf_pkg::MODE_ADD, 8'hFF, 8'h00);
    for (int i = 0; i < 6; i++) send_request(btf_pkg::MODE_ADD, 8'h00, 8'h00);
    send_request(btf_pkg::mode_e'(btf_pkg::MODE_NONE), 8'hAA, 8'h55);
    send_request(btf_pkg::MODE_QUERY, 8'h00, 8'hFF);
    send_request(btf_pkg::MODE_QUERY, 8'h00, 8'h00);
    write_min_total(20'd0);
    send_request(btf_pkg::MODE_QUERY, 8'h00, 8'h00);
    send_request(btf_pkg::MODE_QUERY, 8'h00, 8'h7E);
    send_request(btf_pkg::MODE_QUERY, 8'h00, 8'hFF);
    send_request(btf_pkg::MODE_CLEAR, 8'h00, 8'h00);
    send_request(btf_pkg::MODE_QUERY, 8'h00, 8'h00);
    write_min_total(20'hFFFFF);
    send_request(btf_pkg::MODE_ADD, 8'h55, 8'h00);
    send_request(btf_pkg::MODE_QUERY, 8'h00, 8'h00);

    // random: small alphabet so rows fill up
    write_min_total(20'd3);
    send_words(120, 7);

    // long receiver hold-off while requests keep coming
    hold_off = 300;
    send_words(30, 7);

    write_min_total(20'd1);
    send_request(btf_pkg::MODE_CLEAR, 8'h00, 8'h00);
    send_words(120, 15);
    write_min_total(20'd12);
    send_words(60, 255);

    calm = 1;
    send_words(80, 3);

    in_valid_i <= 0;
    wait (sb.pending.size() == 0);
    repeat (500) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
